[design/ftl_pkg.sv]
// Shared types, codes and constants of the form text lexer.
package ftl_pkg;

    // Default widths and sizes.
    localparam int LINE_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int LINE_W          = 16;
    localparam int CH_W            = 8;
    localparam int MAX_RES         = 3;
    localparam int RES_CNT_W       = 2;

    // Result event codes.
    typedef enum logic [1:0] {
        EV_TEXT       = 2'd0,
        EV_DONE       = 2'd1,
        EV_BAD_STRING = 2'd2
    } event_t;

    // Token kinds.
    typedef enum logic [2:0] {
        TK_NONE   = 3'd0,
        TK_IDENT  = 3'd1,
        TK_STRING = 3'd2,
        TK_INT    = 3'd3,
        TK_FLOAT  = 3'd4,
        TK_CHAR   = 3'd5,
        TK_EOF    = 3'd6
    } kind_t;

    // One result item.
    typedef struct packed {
        event_t            ev;
        kind_t             kind;
        logic [CH_W-1:0]   value;
        logic [LINE_W-1:0] line;
        logic              last;
    } res_t;

    // All the results caused by one source byte.
    typedef struct packed {
        res_t [MAX_RES-1:0]   res;
        logic [RES_CNT_W-1:0] cnt;
    } bundle_t;

endpackage

[design/ftl_ifs.sv]
// Channel interfaces: source bytes in, lexer result items out.
interface ftl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink (input valid, input ch, output ready);
endinterface

interface ftl_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic [2:0]  token_kind;
    logic [7:0]  char_value;
    logic [15:0] line;
    logic        last;

    modport source (output valid, output event_res, output token_kind, output char_value,
                    output line, output last, input ready);
    modport sink (input valid, input event_res, input token_kind, input char_value,
                  input line, input last, output ready);
endinterface

[design/ftl_core.sv]
// Lexer state and the decode of one source byte into up to three result items.
module ftl_core #(
    parameter int LINE_BITS = ftl_pkg::LINE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic [7:0]          ch,
    output ftl_pkg::bundle_t    bundle
);
    import ftl_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE, M_IDENT, M_HEX, M_INT, M_FLOAT, M_QUOTE, M_QEND, M_HASH
    } mode_t;

    localparam logic [CH_W-1:0] CH_NUL    = 8'd0;
    localparam logic [CH_W-1:0] CH_LF     = 8'd10;
    localparam logic [CH_W-1:0] CH_CR     = 8'd13;
    localparam logic [CH_W-1:0] CH_BLANK  = 8'd32;
    localparam logic [CH_W-1:0] CH_QUOTE  = 8'h27;
    localparam logic [CH_W-1:0] CH_HASH   = 8'h23;
    localparam logic [CH_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CH_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CH_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CH_W-1:0] CH_USCORE = 8'h5F;
    localparam logic [CH_W-1:0] CH_LOW_E  = 8'h65;
    localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;

    mode_t                mode_reg, mode_next;
    logic [LINE_BITS-1:0] line_cnt_reg, line_cnt_next;
    logic [LINE_BITS-1:0] tok_line_reg, tok_line_next;
    logic [CH_W-1:0]      code_reg, code_next;

    // Outcome of starting a token on the current byte.
    mode_t                st_mode;
    logic [LINE_BITS-1:0] st_line;
    logic [LINE_BITS-1:0] st_tok;
    logic                 st_clr;
    logic                 st_emit;
    res_t                 st_res;

    logic                 use_start;
    logic [CH_W-1:0]      digit;
    res_t [MAX_RES-1:0]   rs;
    logic [RES_CNT_W-1:0] n;

    function automatic logic is_alpha(input logic [CH_W-1:0] c);
        return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) || (c == CH_USCORE);
    endfunction

    function automatic logic is_digit(input logic [CH_W-1:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_hex(input logic [CH_W-1:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    function automatic logic is_float(input logic [CH_W-1:0] c);
        return is_digit(c) || (c == CH_DOT) || (c == CH_LOW_E) || (c == CH_PLUS) ||
               (c == CH_MINUS);
    endfunction

    function automatic res_t mk(input event_t ev, input kind_t kind,
                                input logic [CH_W-1:0] value,
                                input logic [LINE_BITS-1:0] ln);
        res_t r;
        r.ev    = ev;
        r.kind  = kind;
        r.value = value;
        r.line  = LINE_W'(ln);
        r.last  = 1'b0;
        return r;
    endfunction

    // Start of a new token, or blank skipping, on the current byte.
    always_comb
    begin
        st_mode = M_IDLE;
        st_line = line_cnt_reg;
        st_tok  = tok_line_reg;
        st_clr  = 1'b0;
        st_emit = 1'b0;
        st_res  = mk(EV_DONE, TK_CHAR, ch, line_cnt_reg);
        if (ch == CH_NUL)
        begin
            st_emit = 1'b1;
            st_res  = mk(EV_DONE, TK_EOF, CH_NUL, line_cnt_reg);
        end
        else if (ch <= CH_BLANK)
        begin
            if ((ch == CH_LF) && (line_cnt_reg != '1))
            begin
                st_line = line_cnt_reg + 1'b1;
            end
        end
        else
        begin
            st_tok = line_cnt_reg;
            if (is_alpha(ch))
            begin
                st_mode = M_IDENT;
                st_emit = 1'b1;
                st_res  = mk(EV_TEXT, TK_IDENT, ch, line_cnt_reg);
            end
            else if (ch == CH_DOLLAR)
            begin
                st_mode = M_HEX;
                st_emit = 1'b1;
                st_res  = mk(EV_TEXT, TK_INT, ch, line_cnt_reg);
            end
            else if ((ch == CH_MINUS) || is_digit(ch))
            begin
                st_mode = M_INT;
                st_emit = 1'b1;
                st_res  = mk(EV_TEXT, TK_INT, ch, line_cnt_reg);
            end
            else if (ch == CH_HASH)
            begin
                st_mode = M_HASH;
                st_clr  = 1'b1;
            end
            else if (ch == CH_QUOTE)
            begin
                st_mode = M_QUOTE;
            end
            else
            begin
                st_emit = 1'b1;
            end
        end
    end

    // Per-mode handling of the byte and assembly of the result list.
    always_comb
    begin
        mode_next     = mode_reg;
        line_cnt_next = line_cnt_reg;
        tok_line_next = tok_line_reg;
        code_next     = code_reg;
        use_start     = 1'b0;
        rs            = '0;
        n             = '0;
        digit         = ch - CH_ZERO;
        case (mode_reg)
            M_IDENT:
            begin
                if (is_alpha(ch) || is_digit(ch) || (ch == CH_COLON))
                begin
                    rs[0] = mk(EV_TEXT, TK_IDENT, ch, tok_line_reg);
                end
                else
                begin
                    rs[0]     = mk(EV_DONE, TK_IDENT, CH_NUL, tok_line_reg);
                    use_start = 1'b1;
                end
                n = 2'd1;
            end
            M_HEX:
            begin
                if (is_hex(ch))
                begin
                    rs[0] = mk(EV_TEXT, TK_INT, ch, tok_line_reg);
                end
                else
                begin
                    rs[0]     = mk(EV_DONE, TK_INT, CH_NUL, tok_line_reg);
                    use_start = 1'b1;
                end
                n = 2'd1;
            end
            M_INT:
            begin
                if (is_digit(ch))
                begin
                    rs[0] = mk(EV_TEXT, TK_INT, ch, tok_line_reg);
                end
                else if (is_float(ch))
                begin
                    mode_next = M_FLOAT;
                    rs[0]     = mk(EV_TEXT, TK_FLOAT, ch, tok_line_reg);
                end
                else
                begin
                    rs[0]     = mk(EV_DONE, TK_INT, CH_NUL, tok_line_reg);
                    use_start = 1'b1;
                end
                n = 2'd1;
            end
            M_FLOAT:
            begin
                if (is_float(ch))
                begin
                    rs[0] = mk(EV_TEXT, TK_FLOAT, ch, tok_line_reg);
                end
                else
                begin
                    rs[0]     = mk(EV_DONE, TK_FLOAT, CH_NUL, tok_line_reg);
                    use_start = 1'b1;
                end
                n = 2'd1;
            end
            M_QUOTE:
            begin
                if (ch == CH_QUOTE)
                begin
                    mode_next = M_QEND;
                end
                else if ((ch == CH_NUL) || (ch == CH_LF) || (ch == CH_CR))
                begin
                    rs[0]     = mk(EV_BAD_STRING, TK_STRING, CH_NUL, tok_line_reg);
                    n         = 2'd1;
                    use_start = 1'b1;
                end
                else
                begin
                    rs[0] = mk(EV_TEXT, TK_STRING, ch, tok_line_reg);
                    n     = 2'd1;
                end
            end
            M_QEND:
            begin
                if (ch == CH_QUOTE)
                begin
                    mode_next = M_QUOTE;
                    rs[0]     = mk(EV_TEXT, TK_STRING, ch, tok_line_reg);
                    n         = 2'd1;
                end
                else if (ch == CH_HASH)
                begin
                    mode_next = M_HASH;
                    code_next = '0;
                end
                else
                begin
                    rs[0]     = mk(EV_DONE, TK_STRING, CH_NUL, tok_line_reg);
                    n         = 2'd1;
                    use_start = 1'b1;
                end
            end
            M_HASH:
            begin
                if (is_digit(ch))
                begin
                    // Decimal code, kept modulo 256.
                    code_next = (code_reg << 3) + (code_reg << 1) + digit;
                end
                else
                begin
                    rs[0] = mk(EV_TEXT, TK_STRING, code_reg, tok_line_reg);
                    n     = 2'd1;
                    if (ch == CH_QUOTE)
                    begin
                        mode_next = M_QUOTE;
                    end
                    else if (ch == CH_HASH)
                    begin
                        code_next = '0;
                    end
                    else
                    begin
                        rs[1]     = mk(EV_DONE, TK_STRING, CH_NUL, tok_line_reg);
                        n         = 2'd2;
                        use_start = 1'b1;
                    end
                end
            end
            default:
            begin
                use_start = 1'b1;
            end
        endcase

        // The byte that ended a token is handled as the start of the next.
        if (use_start)
        begin
            mode_next     = st_mode;
            line_cnt_next = st_line;
            tok_line_next = st_tok;
            if (st_clr)
            begin
                code_next = '0;
            end
            if (st_emit)
            begin
                rs[n] = st_res;
                n     = n + 2'd1;
            end
        end

        // Mark the final result of this byte.
        for (int i = 0; i < MAX_RES; i++)
        begin
            if ((n != '0) && (RES_CNT_W'(i) == (n - 2'd1)))
            begin
                rs[i].last = 1'b1;
            end
        end
    end

    assign bundle.res = rs;
    assign bundle.cnt = n;

    // Lexer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= M_IDLE;
            line_cnt_reg <= LINE_BITS'(1);
            tok_line_reg <= LINE_BITS'(1);
            code_reg     <= '0;
        end
        else if (en)
        begin
            mode_reg     <= mode_next;
            line_cnt_reg <= line_cnt_next;
            tok_line_reg <= tok_line_next;
            code_reg     <= code_next;
        end
    end

endmodule

[design/ftl_queue.sv]
// Result queue: holds the results of several bytes and hands them out one item at a time.
module ftl_queue #(
    parameter int DEPTH = ftl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ftl_pkg::bundle_t push_bundle,
    output logic             full,
    output logic             head_valid,
    output ftl_pkg::res_t    head,
    input  logic             head_ready
);
    import ftl_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bundle_t              entries_reg [DEPTH];
    logic [PW-1:0]        wr_ptr_reg;
    logic [PW-1:0]        rd_ptr_reg;
    logic [CW-1:0]        count_reg;
    logic [RES_CNT_W-1:0] sel_reg;
    bundle_t              head_b;
    logic                 pop;
    logic                 pop_last;

    // Head bundle and the result item currently offered from it.
    assign head_b     = entries_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign head       = head_b.res[sel_reg];
    assign full       = (count_reg == CW'(DEPTH));
    assign pop        = head_valid && head_ready;
    assign pop_last   = pop && (sel_reg == (head_b.cnt - 2'd1));

    // Bundle storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_bundle;
        end
    end

    // Pointers, fill count and position inside the head bundle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sel_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_last)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
                sel_reg    <= '0;
            end
            else if (pop)
            begin
                sel_reg <= sel_reg + 2'd1;
            end
            count_reg <= count_reg + CW'(push) - CW'(pop_last);
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("bundle pushed into a full result queue");

    a_head_sane: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> ((head_b.cnt != '0) && (sel_reg < head_b.cnt)))
        else $error("head bundle empty or item index past its count");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (head.last == (sel_reg == (head_b.cnt - 2'd1))))
        else $error("last flag does not match the final item of a bundle");

    a_sel_restart: assert property (@(posedge clk) disable iff (!rst_n)
        pop_last |=> (sel_reg == '0))
        else $error("item index not restarted after a bundle was drained");
`endif

endmodule

[design/form_text_lexer.sv]
// Form text lexer, top level.
// The src channel takes one source byte per item; byte 0 marks end of input.
// The tok channel gives result items: token text bytes, token completions,
// single characters, end of file and invalid string errors, each with the
// token kind and the line on which the token started. A source byte causes
// zero to three result items; last marks the final one of each byte.
// A byte accepted at one edge is decoded in the next cycle from the input
// register and the lexer state, and its results are stored in the result
// queue when the input register moves on; the queue then offers them on
// tok. A new byte is taken in every cycle as long as the queue has room;
// the queue drains one result item per cycle while tok.ready is high, so
// the sustained rate is one byte per cycle while bytes average no more
// than one result and the receiver keeps up. A byte with no results never
// waits for the queue.
// Reset puts the lexer in blank skipping with the line count at one and
// empties the queue. When the receiver stalls, the queue fills and src.ready
// falls once all QUEUE_DEPTH bundles are held and the held byte has results.
module form_text_lexer #(
    parameter int LINE_BITS   = ftl_pkg::LINE_BITS_DEF,
    parameter int QUEUE_DEPTH = ftl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ftl_byte_if.sink   src,
    ftl_res_if.source  tok
);
    import ftl_pkg::*;

    logic            stage_valid_reg;
    logic [CH_W-1:0] ch_reg;
    logic            adv;
    logic            core_en;
    logic            q_full;
    bundle_t         bundle;
    res_t            head;

    // The input register moves on when it is empty, its byte has no results,
    // or the queue can take its results.
    assign adv       = !stage_valid_reg || (bundle.cnt == '0) || !q_full;
    assign src.ready = adv;
    assign core_en   = stage_valid_reg && adv;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            stage_valid_reg <= src.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && src.valid)
        begin
            ch_reg <= src.ch;
        end
    end

    // Byte decode and lexer state.
    ftl_core #(
        .LINE_BITS (LINE_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (core_en),
        .ch     (ch_reg),
        .bundle (bundle)
    );

    // Result queue.
    ftl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (core_en && (bundle.cnt != '0)),
        .push_bundle (bundle),
        .full        (q_full),
        .head_valid  (tok.valid),
        .head        (head),
        .head_ready  (tok.ready)
    );

    // Output payload.
    assign tok.event_res  = head.ev;
    assign tok.token_kind = head.kind;
    assign tok.char_value = head.value;
    assign tok.line       = head.line;
    assign tok.last       = head.last;

endmodule

[sim/tb_form_text_lexer.sv]
// Self-checking testbench for the form text lexer, with a scoreboard and random stalls.
`timescale 1ns / 1ps

module tb_form_text_lexer;
    import ftl_pkg::*;

    localparam logic [7:0]  NUL        = 8'd0;
    localparam logic [7:0]  LF         = 8'd10;
    localparam logic [7:0]  CR         = 8'd13;
    localparam logic [7:0]  BLANK_TOP  = 8'd32;
    localparam logic [15:0] LINE_TOP   = 16'((1 << LINE_BITS_DEF) - 1);
    localparam int          DRAIN_GAP  = 6;
    localparam int          QUIET_MAX  = 2000;
    localparam int          PHASE_LEN  = 40;
    localparam int          REPORT_MAX = 10;

    localparam string IDENT_HEAD = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_";
    localparam string IDENT_TAIL = "ABCXYZabcxyz_:0123456789";
    localparam string HEX_SET    = "0123456789ABCDEFabcdef";
    localparam string DIGIT_SET  = "0123456789";
    localparam string FLOAT_SET  = "0123456789.e+-";
    localparam string CHAR_SET   = "!%&()*+,./;<=>?@[]^{|}~";
    localparam string BLANK_SET  = " \t\n\r";

    // Scoreboard: predicts the result items of each accepted byte and checks the output.
    class lex_scoreboard;
        typedef enum logic [2:0] {
            MD_IDLE, MD_IDENT, MD_HEX, MD_INT, MD_FLOAT, MD_QUOTE, MD_QEND, MD_HASH
        } mode_t;

        mode_t       mode;
        logic [15:0] line_cnt;
        logic [15:0] tok_line;
        logic [7:0]  code_acc;
        res_t        byte_res[$];
        res_t        expect_q[$];
        int          mismatches;

        function new();
            mode       = MD_IDLE;
            line_cnt   = 16'd1;
            tok_line   = 16'd1;
            code_acc   = 8'd0;
            mismatches = 0;
        endfunction

        function bit is_alpha(logic [7:0] c);
            return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_float_char(logic [7:0] c);
            return is_digit(c) || c == "." || c == "e" || c == "+" || c == "-";
        endfunction

        function void emit(event_t ev, kind_t kind, logic [7:0] value, logic [15:0] ln);
            res_t r;
            if (byte_res.size() >= MAX_RES)
                return;
            r.ev    = ev;
            r.kind  = kind;
            r.value = value;
            r.line  = ln;
            r.last  = 1'b0;
            byte_res.push_back(r);
        endfunction

        // A byte seen outside any token: blank, end of file, or the start of a token.
        function void begin_token(logic [7:0] c);
            mode = MD_IDLE;
            if (c == NUL)
                emit(EV_DONE, TK_EOF, 8'd0, line_cnt);
            else if (c <= BLANK_TOP)
            begin
                if (c == LF && line_cnt != LINE_TOP)
                    line_cnt = line_cnt + 16'd1;
            end
            else
            begin
                tok_line = line_cnt;
                if (is_alpha(c))
                begin
                    mode = MD_IDENT;
                    emit(EV_TEXT, TK_IDENT, c, tok_line);
                end
                else if (c == "$")
                begin
                    mode = MD_HEX;
                    emit(EV_TEXT, TK_INT, c, tok_line);
                end
                else if (c == "-" || is_digit(c))
                begin
                    mode = MD_INT;
                    emit(EV_TEXT, TK_INT, c, tok_line);
                end
                else if (c == "#")
                begin
                    mode     = MD_HASH;
                    code_acc = 8'd0;
                end
                else if (c == "'")
                    mode = MD_QUOTE;
                else
                    emit(EV_DONE, TK_CHAR, c, line_cnt);
            end
        endfunction

        // The byte does not belong to the current token: complete it, then start afresh.
        function void close_token(kind_t kind, logic [7:0] c);
            emit(EV_DONE, kind, 8'd0, tok_line);
            begin_token(c);
        endfunction

        function void note_byte(logic [7:0] c);
            res_t r;
            byte_res.delete();
            case (mode)
                MD_IDENT:
                    if (is_alpha(c) || is_digit(c) || c == ":")
                        emit(EV_TEXT, TK_IDENT, c, tok_line);
                    else
                        close_token(TK_IDENT, c);
                MD_HEX:
                    if (is_digit(c) || (c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
                        emit(EV_TEXT, TK_INT, c, tok_line);
                    else
                        close_token(TK_INT, c);
                MD_INT:
                    if (is_digit(c))
                        emit(EV_TEXT, TK_INT, c, tok_line);
                    else if (is_float_char(c))
                    begin
                        mode = MD_FLOAT;
                        emit(EV_TEXT, TK_FLOAT, c, tok_line);
                    end
                    else
                        close_token(TK_INT, c);
                MD_FLOAT:
                    if (is_float_char(c))
                        emit(EV_TEXT, TK_FLOAT, c, tok_line);
                    else
                        close_token(TK_FLOAT, c);
                MD_QUOTE:
                    if (c == "'")
                        mode = MD_QEND;
                    else if (c == NUL || c == LF || c == CR)
                    begin
                        emit(EV_BAD_STRING, TK_STRING, 8'd0, tok_line);
                        begin_token(c);
                    end
                    else
                        emit(EV_TEXT, TK_STRING, c, tok_line);
                MD_QEND:
                    if (c == "'")
                    begin
                        mode = MD_QUOTE;
                        emit(EV_TEXT, TK_STRING, c, tok_line);
                    end
                    else if (c == "#")
                    begin
                        mode     = MD_HASH;
                        code_acc = 8'd0;
                    end
                    else
                        close_token(TK_STRING, c);
                MD_HASH:
                    if (is_digit(c))
                        code_acc = code_acc * 8'd10 + (c - "0");
                    else
                    begin
                        emit(EV_TEXT, TK_STRING, code_acc, tok_line);
                        if (c == "'")
                            mode = MD_QUOTE;
                        else if (c == "#")
                            code_acc = 8'd0;
                        else
                            close_token(TK_STRING, c);
                    end
                default:
                    begin_token(c);
            endcase
            if (byte_res.size() > 0)
            begin
                r      = byte_res.pop_back();
                r.last = 1'b1;
                byte_res.push_back(r);
            end
            foreach (byte_res[i])
                expect_q.push_back(byte_res[i]);
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (expect_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("Unexpected result item: ev=%0d kind=%0d value=%02h line=%0d last=%0d",
                             got.ev, got.kind, got.value, got.line, got.last);
                return;
            end
            want = expect_q.pop_front();
            if (got.ev != want.ev || got.kind != want.kind || got.value != want.value ||
                got.line != want.line || got.last != want.last)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("Mismatch: expected ev=%0d kind=%0d value=%02h line=%0d last=%0d",
                             want.ev, want.kind, want.value, want.line, want.last);
                    $display("          actual   ev=%0d kind=%0d value=%02h line=%0d last=%0d",
                             got.ev, got.kind, got.value, got.line, got.last);
                end
            end
        endfunction

        function bit busy();
            return expect_q.size() != 0;
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    int            src_idle_pct;
    int            snk_idle_pct;
    logic [7:0]    burst[$];
    lex_scoreboard sb = new();

    ftl_byte_if src_ch();
    ftl_res_if  tok_ch();

    form_text_lexer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (src_ch),
        .tok   (tok_ch)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result side: random back-pressure and checking of every accepted item.
    initial
    begin
        res_t got;
        tok_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (tok_ch.valid && tok_ch.ready)
            begin
                got.ev    = event_t'(tok_ch.event_res);
                got.kind  = kind_t'(tok_ch.token_kind);
                got.value = tok_ch.char_value;
                got.line  = tok_ch.line;
                got.last  = tok_ch.last;
                sb.check_result(got);
            end
            tok_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Watchdog: ends the run when no item moves on either channel for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_MAX)
        begin
            @(posedge clk);
            if ((src_ch.valid && src_ch.ready) || (tok_ch.valid && tok_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no item moved for %0d cycles", QUIET_MAX);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    function automatic void queue_text(string s);
        for (int i = 0; i < s.len(); i++)
            burst.push_back(s[i]);
    endfunction

    // A byte that may stand inside quotes without ending the string.
    function automatic logic [7:0] quoted_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255, 1));
        while (c == LF || c == CR || c == "'");
        return c;
    endfunction

    // Offers one byte, with random idle cycles first, and waits for it to be taken.
    task automatic send_byte(input logic [7:0] c);
        while ($urandom_range(99) < src_idle_pct)
        begin
            src_ch.valid <= 1'b0;
            @(posedge clk);
        end
        src_ch.valid <= 1'b1;
        src_ch.ch    <= c;
        do
            @(posedge clk);
        while (!src_ch.ready);
        sb.note_byte(c);
    endtask

    task automatic send_burst(inout int sent);
        foreach (burst[i])
            send_byte(burst[i]);
        sent += burst.size();
        burst.delete();
    endtask

    // Stops sending until every expected item has come and the lexer has settled.
    task automatic drain_lexer();
        src_ch.valid <= 1'b0;
        while (sb.busy())
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    // Builds one random token, mostly well formed, followed by optional blanks.
    task automatic build_token();
        int sel;
        int n;
        sel = $urandom_range(99);
        if (sel < 15)
        begin
            burst.push_back(pick(IDENT_HEAD));
            n = $urandom_range(5);
            repeat (n) burst.push_back(pick(IDENT_TAIL));
        end
        else if (sel < 25)
        begin
            burst.push_back("$");
            n = $urandom_range(4);
            repeat (n) burst.push_back(pick(HEX_SET));
        end
        else if (sel < 52)
        begin
            // Integers, with a lone minus now and then, and floats when sel is high.
            if ($urandom_range(9) < 3)
            begin
                burst.push_back("-");
                n = $urandom_range(3);
            end
            else
                n = $urandom_range(4, 1);
            repeat (n) burst.push_back(pick(DIGIT_SET));
            if (sel >= 40)
            begin
                n = $urandom_range(4, 1);
                repeat (n) burst.push_back(pick(FLOAT_SET));
            end
        end
        else if (sel < 70)
        begin
            // A string of quoted segments and character codes.
            n = $urandom_range(3, 1);
            repeat (n)
            begin
                if ($urandom_range(1))
                begin
                    burst.push_back("'");
                    repeat ($urandom_range(4))
                    begin
                        if ($urandom_range(4) == 0)
                            queue_text("''");
                        else
                            burst.push_back(quoted_byte());
                    end
                    burst.push_back("'");
                end
                else
                begin
                    burst.push_back("#");
                    repeat ($urandom_range(3)) burst.push_back(pick(DIGIT_SET));
                end
            end
        end
        else if (sel < 78)
        begin
            if ($urandom_range(1))
                burst.push_back(pick(CHAR_SET));
            else
                burst.push_back(8'($urandom_range(255, 127)));
        end
        else if (sel < 85)
        begin
            // An unterminated string broken by a line end or end of input.
            burst.push_back("'");
            repeat ($urandom_range(3)) burst.push_back(quoted_byte());
            case ($urandom_range(2))
                0: burst.push_back(NUL);
                1: burst.push_back(LF);
                default: burst.push_back(CR);
            endcase
        end
        else if (sel < 88)
            burst.push_back(NUL);
        else
        begin
            n = $urandom_range(3, 1);
            repeat (n) burst.push_back(8'($urandom_range(255)));
        end
        // Separating blanks.
        if ($urandom_range(9) < 6)
        begin
            n = $urandom_range(3, 1);
            repeat (n)
            begin
                if ($urandom_range(3) == 0)
                    burst.push_back(8'($urandom_range(32, 1)));
                else
                    burst.push_back(pick(BLANK_SET));
            end
        end
    endtask

    // Stimulus: directed bytes, three random phases with different stalls, then a
    // closing line of tokens and end of input.
    initial
    begin
        int sent;
        src_ch.valid = 1'b0;
        src_ch.ch    = 8'd0;
        rst_n        = 1'b0;
        src_idle_pct = 32;
        snk_idle_pct = 69;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 3; phase++)
        begin
            sent = 0;
            if (phase == 1)
            begin
                src_idle_pct = 69;
                snk_idle_pct = 32;
            end
            else if (phase == 2)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            if (phase == 0)
            begin
                // Identifier, hex, float, lone minus, doubled quote, code mod 256,
                // empty code, line end in quotes, high single char, end of file.
                queue_text("_9:$aFg-5.e+ -'a'''#300##'\n");
                burst.push_back(8'hFF);
                burst.push_back(NUL);
                send_burst(sent);
                drain_lexer();
                sent = 0;
            end
            while (sent < PHASE_LEN)
            begin
                build_token();
                send_burst(sent);
                if ($urandom_range(59) == 0)
                    drain_lexer();
            end
            drain_lexer();
        end

        // A few tokens on a new line, then end of input.
        queue_text("k\n7 ");
        burst.push_back(NUL);
        send_burst(sent);
        drain_lexer();

        if (sb.mismatches == 0 && !sb.busy())
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
